// ===== rtl/core/pps_pkg.sv =====
// Shared types and constants of the preemptive priority scheduler.
// No dependencies; every other file of the block uses it.
package pps_pkg;

    // Fixed field widths of the request and response transfers
    localparam int ID_W       = 8;
    localparam int PRIO_IN_W  = 8;
    localparam int PRIO_EXT_W = 16;
    localparam int BURST_W    = 16;
    localparam int ORDER_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int RES_TIME_W = 16;

    // Request kinds
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED      = 3'd0,
        ST_FULL       = 3'd1,
        ST_ZERO_BURST = 3'd2,
        ST_IDLE_TICK  = 3'd3,
        ST_RAN        = 3'd4,
        ST_FINISHED   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_CALC1,
        S_CALC2,
        S_OUT
    } t_state;

    // Job table control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic set_vld;
        logic clr_vld;
    } t_tbl_ctl;

endpackage

// ===== rtl/core/pps_req_if.sv =====
// Request channel: valid/ready handshake carrying one add or tick request.
// Depends on pps_pkg for field widths.
interface pps_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [pps_pkg::ID_W-1:0]    job_id;
    logic [pps_pkg::PRIO_IN_W-1:0] job_priority;
    logic [pps_pkg::BURST_W-1:0] burst_length;

    modport source (
        output valid, req_type, job_id, job_priority, burst_length,
        input  ready
    );
    modport sink (
        input  valid, req_type, job_id, job_priority, burst_length,
        output ready
    );
endinterface

// ===== rtl/core/pps_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one scheduler result.
// Depends on pps_pkg for field widths.
interface pps_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [pps_pkg::STATUS_W-1:0]   status;
    logic [pps_pkg::ID_W-1:0]       served_id;
    logic [pps_pkg::RES_TIME_W-1:0] completion_time;
    logic [pps_pkg::RES_TIME_W-1:0] turnaround;
    logic [pps_pkg::RES_TIME_W-1:0] waiting;

    modport source (
        output valid, status, served_id, completion_time, turnaround, waiting,
        input  ready
    );
    modport sink (
        input  valid, status, served_id, completion_time, turnaround, waiting,
        output ready
    );
endinterface

// ===== rtl/core/preemptive_priority_scheduler_core.sv =====
// Preemptive priority scheduler core: top level, sequencer and result register.
// Depends on pps_pkg, pps_req_if, pps_rsp_if, pps_cmp_unit and pps_job_table.
//
// The core holds up to JOB_SLOTS jobs. An add request stores a job in the
// lowest free slot, stamped with the current tick and an admission number;
// a full table (reported first) or a zero burst rejects it without changing
// anything. A tick request runs the valid job with the highest priority for
// one unit (ties go to the job admitted last, then to the lower slot), and
// always advances the tick counter, which wraps at TIME_BITS. A tick with no
// job is an idle tick. Every request gives exactly one result transfer; a
// finished job also reports completion time, turnaround and waiting time.
// Timing: one request is handled at a time. The sequencer walks the table
// through its single read port, one slot per cycle, through one shared
// compare unit. An add or an idle tick passes through the scan, drain,
// decide and output states; a tick that runs a job also passes through
// CALC1, and a tick that finishes a job through CALC1 and CALC2. While the
// output register is still full, the sequencer waits in the output state.
// The result sits in an output register, so the next request is taken while
// a result still waits for the sink. No clearing pass is needed after reset.
module preemptive_priority_scheduler_core #(
    parameter int JOB_SLOTS     = 16,
    parameter int PRIORITY_BITS = 8,
    parameter int TIME_BITS     = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pps_req_if.sink   i_req,
    pps_rsp_if.source o_rsp
);

    localparam int IW = $clog2(JOB_SLOTS);
    // width that holds both a tick value and a burst
    localparam int WW = (TIME_BITS > pps_pkg::BURST_W) ? TIME_BITS : pps_pkg::BURST_W;

    typedef struct packed {
        logic [pps_pkg::ID_W-1:0]    job_id;
        logic [PRIORITY_BITS-1:0]    prio;
        logic [pps_pkg::BURST_W-1:0] burst;
        logic [pps_pkg::BURST_W-1:0] remaining;
        logic [TIME_BITS-1:0]        arrival;
        logic [pps_pkg::ORDER_W-1:0] order;
    } t_job_rec;

    localparam int REC_W = $bits(t_job_rec);

    // sequencer state
    pps_pkg::t_state r_state, n_state;

    // latched request
    logic                           r_req_type, n_req_type;
    logic [pps_pkg::ID_W-1:0]       r_job_id, n_job_id;
    logic [pps_pkg::PRIO_IN_W-1:0]  r_job_prio, n_job_prio;
    logic [pps_pkg::BURST_W-1:0]    r_burst, n_burst;

    // scan
    logic [IW-1:0]                  r_idx, n_idx;
    logic                           r_pend, n_pend;
    logic [IW-1:0]                  r_pidx, n_pidx;
    logic                           r_have_free, n_have_free;
    logic [IW-1:0]                  r_free_idx, n_free_idx;
    logic                           r_have_best, n_have_best;
    logic [IW-1:0]                  r_best_idx, n_best_idx;
    logic [pps_pkg::ORDER_W-1:0]    r_best_age, n_best_age;
    t_job_rec                       r_best_rec, n_best_rec;

    // timekeeping and arithmetic
    logic [TIME_BITS-1:0]           r_time, n_time;
    logic [pps_pkg::ORDER_W-1:0]    r_admit, n_admit;
    logic [pps_pkg::BURST_W-1:0]    r_rem, n_rem;
    logic [TIME_BITS-1:0]           r_ct, n_ct;
    logic [TIME_BITS-1:0]           r_tat, n_tat;

    // staged result
    pps_pkg::t_status                 r_res_status, n_res_status;
    logic [pps_pkg::ID_W-1:0]         r_res_id, n_res_id;
    logic [pps_pkg::RES_TIME_W-1:0]   r_res_ct, n_res_ct;
    logic [pps_pkg::RES_TIME_W-1:0]   r_res_tat, n_res_tat;
    logic [pps_pkg::RES_TIME_W-1:0]   r_res_wait, n_res_wait;

    // output register
    logic                             r_out_valid;
    logic [pps_pkg::STATUS_W-1:0]     r_out_status;
    logic [pps_pkg::ID_W-1:0]         r_out_id;
    logic [pps_pkg::RES_TIME_W-1:0]   r_out_ct;
    logic [pps_pkg::RES_TIME_W-1:0]   r_out_tat;
    logic [pps_pkg::RES_TIME_W-1:0]   r_out_wait;
    logic                             load_out;

    // table and compare unit wiring
    pps_pkg::t_tbl_ctl                tbl_ctl;
    logic [IW-1:0]                    wr_addr;
    t_job_rec                         wr_rec;
    logic                             rd_valid;
    logic [REC_W-1:0]                 rd_data;
    t_job_rec                         rd_rec;
    logic                             cmp_take;
    logic [pps_pkg::ORDER_W-1:0]      cmp_age;

    // helpers
    logic [pps_pkg::PRIO_EXT_W-1:0]   prio_ext;
    t_job_rec                         add_rec;
    t_job_rec                         wb_rec;
    logic [WW-1:0]                    ct_ext;
    logic [WW-1:0]                    tat_ext;
    logic [WW-1:0]                    burst_ext;
    logic [WW-1:0]                    wait_ext;

    assign rd_rec = t_job_rec'(rd_data);

    pps_job_table #(
        .SLOTS (JOB_SLOTS),
        .REC_W (REC_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (tbl_ctl),
        .i_wr_addr  (wr_addr),
        .i_wr_data  (wr_rec),
        .i_rd_addr  (r_idx),
        .o_rd_valid (rd_valid),
        .o_rd_data  (rd_data)
    );

    pps_cmp_unit #(
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cmp (
        .i_cand_valid (r_pend && rd_valid),
        .i_cand_prio  (rd_rec.prio),
        .i_cand_order (rd_rec.order),
        .i_admit      (r_admit),
        .i_have_best  (r_have_best),
        .i_best_prio  (r_best_rec.prio),
        .i_best_age   (r_best_age),
        .o_take       (cmp_take),
        .o_cand_age   (cmp_age)
    );

    // new job record, priority trimmed or widened to PRIORITY_BITS
    always_comb begin
        prio_ext          = pps_pkg::PRIO_EXT_W'(r_job_prio);
        add_rec.job_id    = r_job_id;
        add_rec.prio      = prio_ext[PRIORITY_BITS-1:0];
        add_rec.burst     = r_burst;
        add_rec.remaining = r_burst;
        add_rec.arrival   = r_time;
        add_rec.order     = r_admit;
    end

    // served job written back with one unit less to run
    always_comb begin
        wb_rec           = r_best_rec;
        wb_rec.remaining = r_rem;
    end

    // waiting = turnaround - burst, clamped at zero
    always_comb begin
        ct_ext    = WW'(r_ct);
        tat_ext   = WW'(r_tat);
        burst_ext = WW'(r_best_rec.burst);
        wait_ext  = (tat_ext > burst_ext) ? (tat_ext - burst_ext) : '0;
    end

    always_comb begin
        n_state      = r_state;
        n_req_type   = r_req_type;
        n_job_id     = r_job_id;
        n_job_prio   = r_job_prio;
        n_burst      = r_burst;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_have_free  = r_have_free;
        n_free_idx   = r_free_idx;
        n_have_best  = r_have_best;
        n_best_idx   = r_best_idx;
        n_best_age   = r_best_age;
        n_best_rec   = r_best_rec;
        n_time       = r_time;
        n_admit      = r_admit;
        n_rem        = r_rem;
        n_ct         = r_ct;
        n_tat        = r_tat;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_ct     = r_res_ct;
        n_res_tat    = r_res_tat;
        n_res_wait   = r_res_wait;
        tbl_ctl      = '0;
        wr_addr      = r_free_idx;
        wr_rec       = add_rec;
        load_out     = 1'b0;

        // slot data returned from the previous read
        if (r_pend) begin
            if (r_req_type == pps_pkg::REQ_TICK) begin
                if (cmp_take) begin
                    n_have_best = 1'b1;
                    n_best_idx  = r_pidx;
                    n_best_age  = cmp_age;
                    n_best_rec  = rd_rec;
                end
            end else if (!rd_valid && !r_have_free) begin
                n_have_free = 1'b1;
                n_free_idx  = r_pidx;
            end
        end

        case (r_state)
            pps_pkg::S_IDLE: begin
                n_pend = 1'b0;
                if (i_req.valid) begin
                    n_req_type  = i_req.req_type;
                    n_job_id    = i_req.job_id;
                    n_job_prio  = i_req.job_priority;
                    n_burst     = i_req.burst_length;
                    n_idx       = '0;
                    n_have_free = 1'b0;
                    n_have_best = 1'b0;
                    n_state     = pps_pkg::S_SCAN;
                end
            end
            pps_pkg::S_SCAN: begin
                tbl_ctl.rd_en = 1'b1;
                n_pend        = 1'b1;
                n_pidx        = r_idx;
                if (r_idx == IW'(JOB_SLOTS - 1)) begin
                    n_state = pps_pkg::S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            pps_pkg::S_DRAIN: begin
                n_pend  = 1'b0;
                n_state = pps_pkg::S_DECIDE;
            end
            pps_pkg::S_DECIDE: begin
                n_res_id   = '0;
                n_res_ct   = '0;
                n_res_tat  = '0;
                n_res_wait = '0;
                n_state    = pps_pkg::S_OUT;
                if (r_req_type == pps_pkg::REQ_ADD) begin
                    if (!r_have_free) begin
                        n_res_status = pps_pkg::ST_FULL;
                    end else if (r_burst == '0) begin
                        n_res_status = pps_pkg::ST_ZERO_BURST;
                    end else begin
                        tbl_ctl.wr_en   = 1'b1;
                        tbl_ctl.set_vld = 1'b1;
                        n_admit         = r_admit + 1'b1;
                        n_res_status    = pps_pkg::ST_ADDED;
                    end
                end else if (!r_have_best) begin
                    n_res_status = pps_pkg::ST_IDLE_TICK;
                    n_time       = r_time + 1'b1;
                end else begin
                    n_rem   = r_best_rec.remaining - 1'b1;
                    n_ct    = r_time + 1'b1;
                    n_state = pps_pkg::S_CALC1;
                end
            end
            pps_pkg::S_CALC1: begin
                wr_addr = r_best_idx;
                wr_rec  = wb_rec;
                n_time  = r_ct;
                n_tat   = r_ct - r_best_rec.arrival;
                if (r_rem == '0) begin
                    tbl_ctl.clr_vld = 1'b1;
                    n_state         = pps_pkg::S_CALC2;
                end else begin
                    tbl_ctl.wr_en = 1'b1;
                    n_res_status  = pps_pkg::ST_RAN;
                    n_res_id      = r_best_rec.job_id;
                    n_state       = pps_pkg::S_OUT;
                end
            end
            pps_pkg::S_CALC2: begin
                n_res_status = pps_pkg::ST_FINISHED;
                n_res_id     = r_best_rec.job_id;
                n_res_ct     = ct_ext[pps_pkg::RES_TIME_W-1:0];
                n_res_tat    = tat_ext[pps_pkg::RES_TIME_W-1:0];
                n_res_wait   = wait_ext[pps_pkg::RES_TIME_W-1:0];
                n_state      = pps_pkg::S_OUT;
            end
            pps_pkg::S_OUT: begin
                // hand over once the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = pps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pps_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_have_free <= 1'b0;
            r_have_best <= 1'b0;
            r_time      <= '0;
            r_admit     <= '0;
        end else begin
            r_pend      <= n_pend;
            r_have_free <= n_have_free;
            r_have_best <= n_have_best;
            r_time      <= n_time;
            r_admit     <= n_admit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_type   <= n_req_type;
        r_job_id     <= n_job_id;
        r_job_prio   <= n_job_prio;
        r_burst      <= n_burst;
        r_idx        <= n_idx;
        r_pidx       <= n_pidx;
        r_free_idx   <= n_free_idx;
        r_best_idx   <= n_best_idx;
        r_best_age   <= n_best_age;
        r_best_rec   <= n_best_rec;
        r_rem        <= n_rem;
        r_ct         <= n_ct;
        r_tat        <= n_tat;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_ct     <= n_res_ct;
        r_res_tat    <= n_res_tat;
        r_res_wait   <= n_res_wait;
    end

    // output register: holds a result until the sink takes the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_status <= r_res_status;
            r_out_id     <= r_res_id;
            r_out_ct     <= r_res_ct;
            r_out_tat    <= r_res_tat;
            r_out_wait   <= r_res_wait;
        end
    end

    assign i_req.ready           = (r_state == pps_pkg::S_IDLE);
    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.served_id       = r_out_id;
    assign o_rsp.completion_time = r_out_ct;
    assign o_rsp.turnaround      = r_out_tat;
    assign o_rsp.waiting         = r_out_wait;

`ifndef ASSERT_OFF
    // the admission counter only ever steps by one
    a_admit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_admit == $past(r_admit)) || (r_admit == $past(r_admit) + 1'b1))
        else $error("admission counter jumped");

    // an add request never moves the tick counter
    a_add_keeps_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != pps_pkg::S_IDLE) && (r_req_type == pps_pkg::REQ_ADD) |=> $stable(r_time))
        else $error("tick counter moved during an add");

    // a served job implies the scan found one
    a_served_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pps_pkg::S_OUT) &&
        ((r_res_status == pps_pkg::ST_RAN) || (r_res_status == pps_pkg::ST_FINISHED))
        |-> r_have_best)
        else $error("job served with no winner from the scan");

    // a result is only loaded when the output register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || o_rsp.ready))
        else $error("pending result overwritten");
`endif

endmodule

// ===== rtl/core/pps_cmp_unit.sv =====
// Shared priority/age compare unit, used once per scanned slot.
// Depends on pps_pkg for the admission order width.
module pps_cmp_unit #(
    parameter int PRIORITY_BITS = 8
) (
    input  logic                         i_cand_valid,
    input  logic [PRIORITY_BITS-1:0]     i_cand_prio,
    input  logic [pps_pkg::ORDER_W-1:0]  i_cand_order,
    input  logic [pps_pkg::ORDER_W-1:0]  i_admit,
    input  logic                         i_have_best,
    input  logic [PRIORITY_BITS-1:0]     i_best_prio,
    input  logic [pps_pkg::ORDER_W-1:0]  i_best_age,
    output logic                         o_take,
    output logic [pps_pkg::ORDER_W-1:0]  o_cand_age
);

    // age wraps modulo 2^16; smaller age = admitted more recently
    assign o_cand_age = i_admit - i_cand_order;

    assign o_take = i_cand_valid &&
                    (!i_have_best ||
                     (i_cand_prio > i_best_prio) ||
                     ((i_cand_prio == i_best_prio) && (o_cand_age < i_best_age)));

endmodule

// ===== rtl/core/pps_job_table.sv =====
// Job table: record memory with one write and one registered read port,
// plus per-slot valid flags. Depends on pps_pkg for the control struct.
module pps_job_table #(
    parameter int SLOTS = 16,
    parameter int REC_W = 80
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pps_pkg::t_tbl_ctl          i_ctl,
    input  logic [$clog2(SLOTS)-1:0]   i_wr_addr,
    input  logic [REC_W-1:0]           i_wr_data,
    input  logic [$clog2(SLOTS)-1:0]   i_rd_addr,
    output logic                       o_rd_valid,
    output logic [REC_W-1:0]           o_rd_data
);

    logic [REC_W-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            o_rd_data  <= r_mem[i_rd_addr];
            o_rd_valid <= r_valid[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.set_vld) begin
            r_valid[i_wr_addr] <= 1'b1;
        end else if (i_ctl.clr_vld) begin
            r_valid[i_wr_addr] <= 1'b0;
        end
    end

endmodule
